// ===== design/wvn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvn_pkg
// Shared types and constants for the weight vector norm unit.
// ----------------------------------------------------------------------------
package wvn_pkg;

   localparam int OUT_BITS      = 31;
   localparam int MODE_BITS     = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index taken from the word part of the address
   localparam logic CSR_IDX_NORM_MODE = 1'b0;

   typedef enum logic [MODE_BITS-1:0] {
      NORM_MAX    = 2'd0,
      NORM_SUM    = 2'd1,
      NORM_EUCLID = 2'd2
   } norm_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_max;
      logic clear;
   } acc_ctl_type;

endpackage
`default_nettype wire

// ===== design/wvn_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvn_mul
// Shift-add squarer: one multiplier bit per cycle, product LSB shifted out.
// ----------------------------------------------------------------------------
module wvn_mul import wvn_pkg::*; #(
   parameter int WEIGHT_BITS = 31
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [WEIGHT_BITS-1:0]     mcand,
   output logic                            done,
   output logic [2*WEIGHT_BITS-1:0]        product
);

   localparam int CNT_BITS = $clog2(WEIGHT_BITS);

   logic                       busy_ff, busy_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [WEIGHT_BITS-1:0]     mcand_ff, mcand_in;
   logic [2*WEIGHT_BITS-1:0]   prod_ff, prod_in;
   logic [WEIGHT_BITS:0]       partial;

   always_comb begin
      partial  = {1'b0, prod_ff[2*WEIGHT_BITS-1:WEIGHT_BITS]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_BITS'(WEIGHT_BITS - 1);
         mcand_in = mcand;
         prod_in  = {{WEIGHT_BITS{1'b0}}, mcand};
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[WEIGHT_BITS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign done    = busy_ff && (cnt_ff == '0);
   assign product = prod_ff;

endmodule
`default_nettype wire

// ===== design/wvn_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvn_acc
// Bit-serial accumulator: saturating add or running maximum, LSB first.
// ----------------------------------------------------------------------------
module wvn_acc import wvn_pkg::*; #(
   parameter int ACC_BITS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire acc_ctl_type             ctl,
   input  wire logic [ACC_BITS-1:0]     addend,
   input  wire logic                    addend_big,
   output logic                         done,
   output logic [ACC_BITS-1:0]          acc_value,
   output logic                         overflow
);

   localparam int CNT_BITS = $clog2(ACC_BITS);

   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic [ACC_BITS-1:0] add_ff, add_in;
   logic                big_ff, big_in;
   logic                max_ff, max_in;
   logic                carry_ff, carry_in;
   logic                gt_ff, gt_in;
   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                a_bit, b_bit, sum_bit, carry_next, gt_next;
   logic [ACC_BITS-1:0] add_rot, acc_rot;

   always_comb begin
      a_bit      = acc_ff[0];
      b_bit      = add_ff[0];
      sum_bit    = a_bit ^ b_bit ^ carry_ff;
      carry_next = (a_bit & b_bit) | (carry_ff & (a_bit ^ b_bit));
      // first differing bit from the top decides, so later bits override
      gt_next    = (a_bit != b_bit) ? b_bit : gt_ff;
      add_rot    = {b_bit, add_ff[ACC_BITS-1:1]};
      acc_rot    = {(max_ff ? a_bit : sum_bit), acc_ff[ACC_BITS-1:1]};

      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      add_in   = add_ff;
      big_in   = big_ff;
      max_in   = max_ff;
      carry_in = carry_ff;
      gt_in    = gt_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;

      priority if (ctl.clear) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (ctl.start) begin
         add_in   = addend;
         big_in   = addend_big;
         max_in   = ctl.is_max;
         carry_in = 1'b0;
         gt_in    = 1'b0;
         busy_in  = 1'b1;
         cnt_in   = CNT_BITS'(ACC_BITS - 1);
      end else if (busy_ff) begin
         add_in   = add_rot;
         acc_in   = acc_rot;
         carry_in = carry_next;
         gt_in    = gt_next;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            if (max_ff) begin
               if (gt_next) begin
                  acc_in = add_rot;
               end
            end else if (carry_next || big_ff) begin
               acc_in = '1;
               ovf_in = 1'b1;
            end
         end
      end else begin
         // idle: everything holds
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         ovf_ff  <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         ovf_ff  <= ovf_in;
         busy_ff <= busy_in;
      end
      add_ff   <= add_in;
      big_ff   <= big_in;
      max_ff   <= max_in;
      carry_ff <= carry_in;
      gt_ff    <= gt_in;
      cnt_ff   <= cnt_in;
   end

   assign done      = busy_ff && (cnt_ff == '0);
   assign acc_value = acc_ff;
   assign overflow  = ovf_ff;

endmodule
`default_nettype wire

// ===== design/wvn_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvn_sqrt
// Digit-by-digit floor square root, two radicand bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module wvn_sqrt import wvn_pkg::*; #(
   parameter int ACC_BITS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ACC_BITS-1:0]            radicand,
   output logic                                done,
   output logic [(ACC_BITS+1)/2-1:0]           root
);

   localparam int SQ_STEPS = (ACC_BITS + 1) / 2;
   localparam int RAD_BITS = 2 * SQ_STEPS;
   localparam int REM_BITS = SQ_STEPS + 3;
   localparam int CNT_BITS = $clog2(SQ_STEPS);

   logic [RAD_BITS-1:0] rad_ff, rad_in, rad_load;
   logic [REM_BITS-1:0] rem_ff, rem_in, rem_sh, trial, diff;
   logic [SQ_STEPS-1:0] root_ff, root_in;
   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                ge;

   if (RAD_BITS > ACC_BITS) begin : g_pad
      assign rad_load = {1'b0, radicand};
   end else begin : g_nopad
      assign rad_load = radicand;
   end

   always_comb begin
      rem_sh  = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1:RAD_BITS-2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      diff    = rem_sh - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rad_in  = rad_load;
         rem_in  = '0;
         root_in = '0;
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(SQ_STEPS - 1);
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
         rem_in  = ge ? diff : rem_sh;
         root_in = {root_ff[SQ_STEPS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = busy_ff && (cnt_ff == '0);
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== design/weight_vector_norm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weight_vector_norm_unit
// Folds the weight components of a vertex into one max, sum or 2-norm value.
// ----------------------------------------------------------------------------
// One component is taken at a time; the unit stalls the request side until it
// is folded in. The accumulator runs bit-serially in every mode; in Euclidean
// mode the shift-add squarer runs before it. The last component of a vertex
// then loads the output register, after the square root in Euclidean mode,
// and waits there if an earlier result has not been taken yet. A result item
// comes only with the last component; the accumulator and overflow mark are
// then cleared.
// ----------------------------------------------------------------------------
module weight_vector_norm_unit import wvn_pkg::*; #(
   parameter int WEIGHT_BITS = 31,
   parameter int ACC_BITS    = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [OUT_BITS-1:0]        req_weight,
   input  wire logic                       req_last_component,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [OUT_BITS-1:0]             rsp_norm_value,
   output logic                            rsp_saturated,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                            csr_pready
);

   localparam int PROD_BITS = 2 * WEIGHT_BITS;
   localparam int SQ_STEPS  = (ACC_BITS + 1) / 2;

   state_type                  state_ff, state_in;
   logic                       go_ff, go_in;
   logic [MODE_BITS-1:0]       norm_mode_ff;
   logic [WEIGHT_BITS-1:0]     weight_ff;
   logic                       last_ff;
   logic                       euclid_ff;
   logic                       max_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]        rsp_value_ff;
   logic                       rsp_sat_ff;

   logic                       accept, cfg_write, cfg_euclid, cfg_max;
   logic                       mul_start, mul_done, sqrt_start, sqrt_done, acc_done;
   logic                       rsp_load;
   acc_ctl_type                acc_ctl;
   logic [PROD_BITS-1:0]       product;
   logic [ACC_BITS-1:0]        prod_ext, addend, acc_value, res_wide;
   logic                       prod_big, addend_big, acc_ovf, clamp;
   logic [SQ_STEPS-1:0]        root;
   logic [OUT_BITS-1:0]        res_value;
   logic                       res_sat;

   assign accept     = req_valid && !req_stall;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_NORM_MODE);
   assign cfg_euclid = (norm_mode_ff == NORM_EUCLID);
   // the unused mode code folds as maximum
   assign cfg_max    = !cfg_euclid && (norm_mode_ff != NORM_SUM);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_NORM_MODE)
                       ? {{(CSR_DATA_BITS-MODE_BITS){1'b0}}, norm_mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_mode_ff <= NORM_MAX;
      end else if (cfg_write) begin
         norm_mode_ff <= csr_pwdata[MODE_BITS-1:0];
      end
   end

   // square width against accumulator width
   if (PROD_BITS > ACC_BITS) begin : g_prod_wide
      assign prod_ext = product[ACC_BITS-1:0];
      assign prod_big = |product[PROD_BITS-1:ACC_BITS];
   end else if (PROD_BITS == ACC_BITS) begin : g_prod_same
      assign prod_ext = product;
      assign prod_big = 1'b0;
   end else begin : g_prod_narrow
      assign prod_ext = {{(ACC_BITS-PROD_BITS){1'b0}}, product};
      assign prod_big = 1'b0;
   end

   assign addend     = euclid_ff ? prod_ext : {{(ACC_BITS-WEIGHT_BITS){1'b0}}, weight_ff};
   assign addend_big = euclid_ff && prod_big;

   wvn_mul #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (weight_ff),
      .done    (mul_done),
      .product (product)
   );

   wvn_acc #(
      .ACC_BITS (ACC_BITS)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl),
      .addend     (addend),
      .addend_big (addend_big),
      .done       (acc_done),
      .acc_value  (acc_value),
      .overflow   (acc_ovf)
   );

   wvn_sqrt #(
      .ACC_BITS (ACC_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_value),
      .done     (sqrt_done),
      .root     (root)
   );

   // result and clamp to the output width
   always_comb begin
      res_wide  = euclid_ff ? ACC_BITS'(root) : acc_value;
      clamp     = |res_wide[ACC_BITS-1:OUT_BITS];
      res_value = clamp ? '1 : res_wide[OUT_BITS-1:0];
      res_sat   = acc_ovf || clamp;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      go_in          = 1'b0;
      req_stall      = 1'b1;
      mul_start      = 1'b0;
      sqrt_start     = 1'b0;
      acc_ctl        = '0;
      acc_ctl.is_max = max_ff;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               go_in    = 1'b1;
               state_in = cfg_euclid ? ST_MUL : ST_ACC;
            end
         end
         ST_MUL: begin
            mul_start = go_ff;
            if (mul_done) begin
               go_in    = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_ctl.start = go_ff;
            if (acc_done) begin
               if (!last_ff) begin
                  state_in = ST_IDLE;
               end else if (euclid_ff) begin
                  go_in    = 1'b1;
                  state_in = ST_SQRT;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SQRT: begin
            sqrt_start = go_ff;
            if (sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load      = 1'b1;
               acc_ctl.clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         weight_ff <= req_weight[WEIGHT_BITS-1:0];
         last_ff   <= req_last_component;
         euclid_ff <= cfg_euclid;
         max_ff    <= cfg_max;
      end
      if (rsp_load) begin
         rsp_value_ff <= res_value;
         rsp_sat_ff   <= res_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
`default_nettype wire

// ===== design/wvn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvn_checker
// Port-level checks for the weight vector norm unit, bound to the top level.
// ----------------------------------------------------------------------------
module wvn_checker import wvn_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [OUT_BITS-1:0]        rsp_norm_value,
   input  wire logic                       rsp_saturated
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm_value)
                                 && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // one item at a time: the request side stalls right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while the previous one is in work");

   // a new result appears only while an item is being finished
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in work");

   // out of reset: nothing pending, ready for an item
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("bad state after reset");

endmodule

bind weight_vector_norm_unit wvn_checker u_wvn_checker (.*);
`default_nettype wire
